/* hdl/lft_pkg.sv */
// Shared types, constants and helper functions of the lane fit tracker.
package lft_pkg;

    // Port field widths.
    localparam int IN_CW     = 12;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int X_W       = 15;

    // Datapath word of the shared arithmetic units.
    localparam int WORD_W = 64;
    localparam int HALF_W = 32;

    // Fraction bits of the slope threshold.
    localparam int FRAC_BITS = 8;

    // Input word kinds.
    localparam logic [1:0] KIND_SEG   = 2'd0;
    localparam logic [1:0] KIND_LAST  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 2'd2;

    // Register reset values.
    localparam logic [CFG_W-1:0] SLOPE_RST  = 12'd128;
    localparam logic [CFG_W-1:0] BOTTOM_RST = 12'd720;
    localparam logic [CFG_W-1:0] TOP_RST    = 12'd396;

    localparam logic [X_W-1:0] X_MAX = 15'h7fff;

    // Side selects.
    localparam logic SIDE_L = 1'b0;
    localparam logic SIDE_R = 1'b1;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IN_CW-1:0] start_x;
        logic [IN_CW-1:0] start_y;
        logic [IN_CW-1:0] end_x;
        logic [IN_CW-1:0] end_y;
    } t_in_word;

    typedef struct packed {
        logic           lanes_valid;
        logic [X_W-1:0] left_bottom_x;
        logic [X_W-1:0] left_top_x;
        logic [X_W-1:0] right_bottom_x;
        logic [X_W-1:0] right_top_x;
    } t_out_word;

    // Request and response of a multi-cycle arithmetic unit.
    typedef struct packed {
        logic              go;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_unit_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } t_unit_rsp;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_PUSH = 7'b0001000,
        S_AVG  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    // Multiplier steps: segment accumulation, then the per-side fit.
    typedef enum logic [3:0] {
        M_SLOPE, M_X0X0, M_X0Y0, M_X1X1, M_X1Y1,
        M_F0, M_F1, M_F2, M_F3, M_F4, M_F5, M_F6, M_F7, M_F8, M_F9
    } t_mstep;

    // Divider steps: lane x at both rows, then the four averages.
    typedef enum logic [2:0] {
        D_XB, D_XT, D_ALB, D_ALT, D_ARB, D_ART
    } t_dstep;

    // Two's complement magnitude of a word.
    function automatic logic [WORD_W-1:0] mag64(input logic [WORD_W-1:0] v);
        return v[WORD_W-1] ? (~v + 64'd1) : v;
    endfunction

    // Clamp a nonnegative lane column to the stored width.
    function automatic logic [X_W-1:0] sat_x(input logic [WORD_W-1:0] v);
        return (|v[WORD_W-2:X_W]) ? X_MAX : v[X_W-1:0];
    endfunction

endpackage

/* hdl/lane_fit_tracker_core.sv */
// Top level of the lane fit tracker: sequencer, fit sums, histories and result register.
//
// Usage: segment words enter on the in channel (valid/ready). Kind 0 is a segment
// with more to follow, kind 1 the last segment of a frame, kind 2 a frame with no
// segments; kind 3 is dropped. Each frame end gives one result word on the out
// channel with the averaged left and right lane columns at the bottom and top rows.
// The user writes configuration over the cfg channel (threshold, bottom row, top row)
// only while the block is idle; the block does not enforce this, it is always ready.
// Arithmetic: one shared multiplier and one divider do all arithmetic.
// A frame end runs ten products and two divisions per side, a walk over the
// histories and four divisions for the averages.
// The in channel is not ready while a word is being worked on or while a result
// waits; a stalled receiver holds the result and the block until it is taken.
// Reset restores the register defaults and clears sums, histories and counters.
module lane_fit_tracker_core #(
    parameter int HISTORY_DEPTH = 5,
    parameter int MAX_SEGMENTS  = 256,
    parameter int COORD_BITS    = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  lft_pkg::t_in_word                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output lft_pkg::t_out_word                 o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lft_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lft_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int WW = lft_pkg::WORD_W;
    localparam int XW = lft_pkg::X_W;
    localparam int CB = COORD_BITS;
    localparam int NW = $clog2(2 * MAX_SEGMENTS + 1);
    localparam int SW = CB + NW;
    localparam int QW = 2 * CB + NW;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int MW = $clog2(HISTORY_DEPTH + 1);
    localparam int AW = XW + MW;

    lft_pkg::t_state r_state;
    lft_pkg::t_mstep r_mstep;
    lft_pkg::t_dstep r_dstep;
    logic            r_mgo;
    logic            r_dgo;
    logic            r_side;
    logic            r_last;

    logic [lft_pkg::CFG_W-1:0] r_thr;
    logic [lft_pkg::CFG_W-1:0] r_bot;
    logic [lft_pkg::CFG_W-1:0] r_top;

    logic [CB-1:0] r_x0, r_y0, r_x1, r_y1;
    logic [CW-1:0] r_seg_cnt;

    // Least-squares sums, one entry per side.
    logic [NW-1:0] r_n   [2];
    logic [SW-1:0] r_sx  [2];
    logic [SW-1:0] r_sy  [2];
    logic [QW-1:0] r_sxx [2];
    logic [QW-1:0] r_sxy [2];

    // Fit temporaries.
    logic [WW-1:0] r_t0, r_d, r_nn, r_den, r_u, r_numb, r_numt;
    logic [WW-1:0] r_xb [2];
    logic [WW-1:0] r_xt [2];
    logic [1:0]    r_sv;

    // Lane histories, entry 0 is the newest.
    logic [XW-1:0] r_hl_b [HISTORY_DEPTH];
    logic [XW-1:0] r_hl_t [HISTORY_DEPTH];
    logic [XW-1:0] r_hr_b [HISTORY_DEPTH];
    logic [XW-1:0] r_hr_t [HISTORY_DEPTH];

    logic [HW-1:0] r_ai;
    logic [AW-1:0] r_lsb, r_lst, r_rsb, r_rst;
    logic [MW-1:0] r_lcnt, r_rcnt;
    logic [XW-1:0] r_alb, r_alt, r_arb, r_art;
    logic [MW-1:0] r_missing;
    logic          r_long;
    lft_pkg::t_out_word r_out;

    logic [CB-1:0] in_x0, in_y0, in_x1, in_y1;
    logic          x_gt, dy_pos;
    logic [CB-1:0] adx, ady;
    logic [NW-1:0] cur_n;
    logic [SW-1:0] cur_sx, cur_sy;
    logic [QW-1:0] cur_sxx, cur_sxy;
    logic [WW-1:0] mp, dq, x_res;
    logic          x_neg, in_acc;
    logic          both_v, none_v, draw_a, hit;
    logic [MW-1:0] mc_next;

    lft_pkg::t_unit_req mul_req, div_req;
    lft_pkg::t_unit_rsp mul_rsp, div_rsp;

    lft_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    lft_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Coordinates are cut to the configured coordinate width.
    assign in_x0 = CB'(i_in_data.start_x);
    assign in_y0 = CB'(i_in_data.start_y);
    assign in_x1 = CB'(i_in_data.end_x);
    assign in_y1 = CB'(i_in_data.end_y);

    assign x_gt   = r_x1 > r_x0;
    assign dy_pos = r_y1 > r_y0;
    assign adx    = x_gt ? (r_x1 - r_x0) : (r_x0 - r_x1);
    assign ady    = dy_pos ? (r_y1 - r_y0) : (r_y0 - r_y1);

    assign cur_n   = r_n[r_side];
    assign cur_sx  = r_sx[r_side];
    assign cur_sy  = r_sy[r_side];
    assign cur_sxx = r_sxx[r_side];
    assign cur_sxy = r_sxy[r_side];

    assign mp = mul_rsp.result;
    assign dq = div_rsp.result;

    // Multiplier operands for each step.
    always_comb begin
        mul_req.go = r_mgo;
        unique case (r_mstep)
            lft_pkg::M_SLOPE: begin mul_req.a = WW'(r_thr);   mul_req.b = WW'(adx);     end
            lft_pkg::M_X0X0:  begin mul_req.a = WW'(r_x0);    mul_req.b = WW'(r_x0);    end
            lft_pkg::M_X0Y0:  begin mul_req.a = WW'(r_x0);    mul_req.b = WW'(r_y0);    end
            lft_pkg::M_X1X1:  begin mul_req.a = WW'(r_x1);    mul_req.b = WW'(r_x1);    end
            lft_pkg::M_X1Y1:  begin mul_req.a = WW'(r_x1);    mul_req.b = WW'(r_y1);    end
            lft_pkg::M_F0:    begin mul_req.a = WW'(cur_n);   mul_req.b = WW'(cur_sxx); end
            lft_pkg::M_F1:    begin mul_req.a = WW'(cur_sx);  mul_req.b = WW'(cur_sx);  end
            lft_pkg::M_F2:    begin mul_req.a = WW'(cur_n);   mul_req.b = WW'(cur_sxy); end
            lft_pkg::M_F3:    begin mul_req.a = WW'(cur_sx);  mul_req.b = WW'(cur_sy);  end
            lft_pkg::M_F4:    begin mul_req.a = WW'(cur_n);   mul_req.b = r_nn;         end
            lft_pkg::M_F5:    begin mul_req.a = WW'(cur_sx);  mul_req.b = r_nn;         end
            lft_pkg::M_F6:    begin mul_req.a = WW'(cur_n);   mul_req.b = WW'(r_bot);   end
            lft_pkg::M_F7:    begin mul_req.a = r_t0;         mul_req.b = r_d;          end
            lft_pkg::M_F8:    begin mul_req.a = WW'(cur_n);   mul_req.b = WW'(r_top);   end
            lft_pkg::M_F9:    begin mul_req.a = r_t0;         mul_req.b = r_d;          end
            default:          begin mul_req.a = r_t0;         mul_req.b = r_d;          end
        endcase
    end

    // Divider operands for each step.
    always_comb begin
        div_req.go = r_dgo;
        unique case (r_dstep)
            lft_pkg::D_XB: begin
                div_req.a = lft_pkg::mag64(r_numb);
                div_req.b = lft_pkg::mag64(r_den);
            end
            lft_pkg::D_XT: begin
                div_req.a = lft_pkg::mag64(r_numt);
                div_req.b = lft_pkg::mag64(r_den);
            end
            lft_pkg::D_ALB: begin div_req.a = WW'(r_lsb); div_req.b = WW'(r_lcnt); end
            lft_pkg::D_ALT: begin div_req.a = WW'(r_lst); div_req.b = WW'(r_lcnt); end
            lft_pkg::D_ARB: begin div_req.a = WW'(r_rsb); div_req.b = WW'(r_rcnt); end
            lft_pkg::D_ART: begin div_req.a = WW'(r_rst); div_req.b = WW'(r_rcnt); end
            default: begin
                div_req.a = lft_pkg::mag64(r_numb);
                div_req.b = lft_pkg::mag64(r_den);
            end
        endcase
    end

    // Signed lane column from the unsigned quotient.
    assign x_neg = (r_dstep == lft_pkg::D_XT) ? (r_numt[WW-1] ^ r_den[WW-1])
                                              : (r_numb[WW-1] ^ r_den[WW-1]);
    assign x_res = x_neg ? (~dq + 64'd1) : dq;

    // Frame-end bookkeeping of missing frames.
    assign both_v = r_sv[0] & r_sv[1];
    assign none_v = ~r_sv[0] & ~r_sv[1];
    always_comb begin
        if (both_v) begin
            mc_next = '0;
        end else if (none_v && (r_missing < MW'(HISTORY_DEPTH))) begin
            mc_next = r_missing + 1'b1;
        end else begin
            mc_next = r_missing;
        end
    end
    assign draw_a = !(both_v && r_long);
    assign hit    = draw_a && (mc_next >= MW'(HISTORY_DEPTH));

    assign in_acc = i_in_valid && o_in_ready;

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lft_pkg::S_IDLE;
            r_mstep   <= lft_pkg::M_SLOPE;
            r_dstep   <= lft_pkg::D_XB;
            r_mgo     <= 1'b0;
            r_dgo     <= 1'b0;
            r_side    <= lft_pkg::SIDE_L;
            r_last    <= 1'b0;
            r_thr     <= lft_pkg::SLOPE_RST;
            r_bot     <= lft_pkg::BOTTOM_RST;
            r_top     <= lft_pkg::TOP_RST;
            r_seg_cnt <= '0;
            r_sv      <= '0;
            r_missing <= '0;
            r_long    <= 1'b0;
            for (int s = 0; s < 2; s++) begin
                r_n[s]   <= '0;
                r_sx[s]  <= '0;
                r_sy[s]  <= '0;
                r_sxx[s] <= '0;
                r_sxy[s] <= '0;
            end
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hl_b[i] <= '0;
                r_hl_t[i] <= '0;
                r_hr_b[i] <= '0;
                r_hr_t[i] <= '0;
            end
        end else begin
            r_mgo <= 1'b0;
            r_dgo <= 1'b0;

            // Configuration writes.
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    lft_pkg::REG_SLOPE:  r_thr <= i_cfg_data;
                    lft_pkg::REG_BOTTOM: r_bot <= i_cfg_data;
                    lft_pkg::REG_TOP:    r_top <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                // Take a word and decide its path.
                lft_pkg::S_IDLE: begin
                    if (in_acc) begin
                        if (i_in_data.kind == lft_pkg::KIND_SEG ||
                            i_in_data.kind == lft_pkg::KIND_LAST) begin
                            r_x0   <= in_x0;
                            r_y0   <= in_y0;
                            r_x1   <= in_x1;
                            r_y1   <= in_y1;
                            r_last <= (i_in_data.kind == lft_pkg::KIND_LAST);
                            if (r_seg_cnt >= CW'(MAX_SEGMENTS)) begin
                                if (i_in_data.kind == lft_pkg::KIND_LAST) begin
                                    r_side  <= lft_pkg::SIDE_L;
                                    r_mstep <= lft_pkg::M_F0;
                                    r_mgo   <= 1'b1;
                                    r_state <= lft_pkg::S_MUL;
                                end
                            end else begin
                                r_seg_cnt <= r_seg_cnt + 1'b1;
                                r_mgo     <= 1'b1;
                                r_state   <= lft_pkg::S_MUL;
                                if (in_x0 == in_x1) begin
                                    r_side  <= lft_pkg::SIDE_R;
                                    r_mstep <= lft_pkg::M_X0X0;
                                end else begin
                                    r_mstep <= lft_pkg::M_SLOPE;
                                end
                            end
                        end else if (i_in_data.kind == lft_pkg::KIND_EMPTY) begin
                            r_sv    <= '0;
                            r_state <= lft_pkg::S_PUSH;
                        end
                    end
                end

                // Write back a finished product and start the next one.
                lft_pkg::S_MUL: begin
                    if (mul_rsp.done) begin
                        unique case (r_mstep)
                            lft_pkg::M_SLOPE: begin
                                if ((WW'(ady) << lft_pkg::FRAC_BITS) <= mp) begin
                                    if (r_last) begin
                                        r_side  <= lft_pkg::SIDE_L;
                                        r_mstep <= lft_pkg::M_F0;
                                        r_mgo   <= 1'b1;
                                    end else begin
                                        r_state <= lft_pkg::S_IDLE;
                                    end
                                end else begin
                                    r_side  <= (x_gt == dy_pos) ? lft_pkg::SIDE_R
                                                                : lft_pkg::SIDE_L;
                                    r_mstep <= lft_pkg::M_X0X0;
                                    r_mgo   <= 1'b1;
                                end
                            end
                            lft_pkg::M_X0X0: begin
                                r_n[r_side]   <= cur_n + NW'(2);
                                r_sx[r_side]  <= cur_sx + SW'(r_x0) + SW'(r_x1);
                                r_sy[r_side]  <= cur_sy + SW'(r_y0) + SW'(r_y1);
                                r_sxx[r_side] <= cur_sxx + QW'(mp);
                                r_mstep       <= lft_pkg::M_X0Y0;
                                r_mgo         <= 1'b1;
                            end
                            lft_pkg::M_X0Y0: begin
                                r_sxy[r_side] <= cur_sxy + QW'(mp);
                                r_mstep       <= lft_pkg::M_X1X1;
                                r_mgo         <= 1'b1;
                            end
                            lft_pkg::M_X1X1: begin
                                r_sxx[r_side] <= cur_sxx + QW'(mp);
                                r_mstep       <= lft_pkg::M_X1Y1;
                                r_mgo         <= 1'b1;
                            end
                            lft_pkg::M_X1Y1: begin
                                r_sxy[r_side] <= cur_sxy + QW'(mp);
                                if (r_last) begin
                                    r_side  <= lft_pkg::SIDE_L;
                                    r_mstep <= lft_pkg::M_F0;
                                    r_mgo   <= 1'b1;
                                end else begin
                                    r_state <= lft_pkg::S_IDLE;
                                end
                            end
                            lft_pkg::M_F0: begin
                                r_t0 <= mp;
                                r_mstep <= lft_pkg::M_F1;
                                r_mgo <= 1'b1;
                            end
                            lft_pkg::M_F1: begin
                                r_d <= r_t0 - mp;
                                r_mstep <= lft_pkg::M_F2;
                                r_mgo <= 1'b1;
                            end
                            lft_pkg::M_F2: begin
                                r_t0 <= mp;
                                r_mstep <= lft_pkg::M_F3;
                                r_mgo <= 1'b1;
                            end
                            lft_pkg::M_F3: begin
                                r_nn <= r_t0 - mp;
                                r_mstep <= lft_pkg::M_F4;
                                r_mgo <= 1'b1;
                            end
                            lft_pkg::M_F4: begin
                                r_den <= mp;
                                r_mstep <= lft_pkg::M_F5;
                                r_mgo <= 1'b1;
                            end
                            lft_pkg::M_F5: begin
                                r_u <= mp;
                                r_mstep <= lft_pkg::M_F6;
                                r_mgo <= 1'b1;
                            end
                            lft_pkg::M_F6: begin
                                r_t0 <= mp - WW'(cur_sy);
                                r_mstep <= lft_pkg::M_F7;
                                r_mgo <= 1'b1;
                            end
                            lft_pkg::M_F7: begin
                                r_numb <= mp + r_u;
                                r_mstep <= lft_pkg::M_F8;
                                r_mgo <= 1'b1;
                            end
                            lft_pkg::M_F8: begin
                                r_t0 <= mp - WW'(cur_sy);
                                r_mstep <= lft_pkg::M_F9;
                                r_mgo <= 1'b1;
                            end
                            default: begin
                                r_numt  <= mp + r_u;
                                r_dstep <= lft_pkg::D_XB;
                                r_dgo   <= 1'b1;
                                r_state <= lft_pkg::S_DIV;
                            end
                        endcase
                    end
                end

                // Write back a finished quotient and start the next one.
                lft_pkg::S_DIV: begin
                    if (div_rsp.done) begin
                        unique case (r_dstep)
                            lft_pkg::D_XB: begin
                                r_xb[r_side] <= x_res;
                                r_dstep      <= lft_pkg::D_XT;
                                r_dgo        <= 1'b1;
                            end
                            lft_pkg::D_XT: begin
                                r_xt[r_side] <= x_res;
                                r_sv[r_side] <= (cur_n != '0) && (r_nn != '0) &&
                                                (r_den != '0) && !r_xb[r_side][WW-1] &&
                                                !x_res[WW-1];
                                if (r_side == lft_pkg::SIDE_L) begin
                                    r_side  <= lft_pkg::SIDE_R;
                                    r_mstep <= lft_pkg::M_F0;
                                    r_mgo   <= 1'b1;
                                    r_state <= lft_pkg::S_MUL;
                                end else begin
                                    r_state <= lft_pkg::S_PUSH;
                                end
                            end
                            lft_pkg::D_ALB: begin
                                r_alb   <= (r_lcnt == '0) ? '0 : dq[XW-1:0];
                                r_dstep <= lft_pkg::D_ALT;
                                r_dgo   <= 1'b1;
                            end
                            lft_pkg::D_ALT: begin
                                r_alt   <= (r_lcnt == '0) ? '0 : dq[XW-1:0];
                                r_dstep <= lft_pkg::D_ARB;
                                r_dgo   <= 1'b1;
                            end
                            lft_pkg::D_ARB: begin
                                r_arb   <= (r_rcnt == '0) ? '0 : dq[XW-1:0];
                                r_dstep <= lft_pkg::D_ART;
                                r_dgo   <= 1'b1;
                            end
                            default: begin
                                r_art   <= (r_rcnt == '0) ? '0 : dq[XW-1:0];
                                r_state <= lft_pkg::S_FIN;
                            end
                        endcase
                    end
                end

                // Reject crossed lanes, push valid sides and clear the frame sums.
                lft_pkg::S_PUSH: begin
                    if (r_sv[0] && r_sv[1] &&
                        (r_xt[1] < r_xt[0] || r_xb[1] < r_xb[0])) begin
                        r_sv <= '0;
                    end else begin
                        if (r_sv[0]) begin
                            for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
                                r_hl_b[i] <= r_hl_b[i-1];
                                r_hl_t[i] <= r_hl_t[i-1];
                            end
                            r_hl_b[0] <= lft_pkg::sat_x(r_xb[0]);
                            r_hl_t[0] <= lft_pkg::sat_x(r_xt[0]);
                        end
                        if (r_sv[1]) begin
                            for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
                                r_hr_b[i] <= r_hr_b[i-1];
                                r_hr_t[i] <= r_hr_t[i-1];
                            end
                            r_hr_b[0] <= lft_pkg::sat_x(r_xb[1]);
                            r_hr_t[0] <= lft_pkg::sat_x(r_xt[1]);
                        end
                    end
                    for (int s = 0; s < 2; s++) begin
                        r_n[s]   <= '0;
                        r_sx[s]  <= '0;
                        r_sy[s]  <= '0;
                        r_sxx[s] <= '0;
                        r_sxy[s] <= '0;
                    end
                    r_seg_cnt <= '0;
                    r_ai      <= '0;
                    r_lsb     <= '0;
                    r_lst     <= '0;
                    r_rsb     <= '0;
                    r_rst     <= '0;
                    r_lcnt    <= '0;
                    r_rcnt    <= '0;
                    r_state   <= lft_pkg::S_AVG;
                end

                // Walk the histories, one entry a cycle, summing the nonzero ones.
                lft_pkg::S_AVG: begin
                    if (r_hl_b[r_ai] != '0) begin
                        r_lsb  <= r_lsb + AW'(r_hl_b[r_ai]);
                        r_lst  <= r_lst + AW'(r_hl_t[r_ai]);
                        r_lcnt <= r_lcnt + 1'b1;
                    end
                    if (r_hr_b[r_ai] != '0) begin
                        r_rsb  <= r_rsb + AW'(r_hr_b[r_ai]);
                        r_rst  <= r_rst + AW'(r_hr_t[r_ai]);
                        r_rcnt <= r_rcnt + 1'b1;
                    end
                    if (r_ai == HW'(HISTORY_DEPTH - 1)) begin
                        r_dstep <= lft_pkg::D_ALB;
                        r_dgo   <= 1'b1;
                        r_state <= lft_pkg::S_DIV;
                    end else begin
                        r_ai <= r_ai + 1'b1;
                    end
                end

                // Update the missing-frame state and load the result word.
                lft_pkg::S_FIN: begin
                    r_missing <= mc_next;
                    r_long    <= hit ? 1'b1 : (both_v ? 1'b0 : r_long);
                    if (hit) begin
                        for (int i = 0; i < HISTORY_DEPTH; i++) begin
                            r_hl_b[i] <= '0;
                            r_hl_t[i] <= '0;
                            r_hr_b[i] <= '0;
                            r_hr_t[i] <= '0;
                        end
                    end
                    if (draw_a && !hit) begin
                        r_out.lanes_valid    <= 1'b1;
                        r_out.left_bottom_x  <= r_alb;
                        r_out.left_top_x     <= r_alt;
                        r_out.right_bottom_x <= r_arb;
                        r_out.right_top_x    <= r_art;
                    end else begin
                        r_out <= '0;
                    end
                    r_state <= lft_pkg::S_OUT;
                end

                // Hold the result word until it is taken.
                lft_pkg::S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= lft_pkg::S_IDLE;
                    end
                end

                default: r_state <= lft_pkg::S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == lft_pkg::S_IDLE);
    assign o_out_valid = (r_state == lft_pkg::S_OUT);
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // The block never takes a word while a result is pending.
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input ready while a result word is pending");

    // The missing-frame count saturates at the history depth.
    a_missing_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_missing <= MW'(HISTORY_DEPTH))
        else $error("missing-frame count above history depth");

    // Taking the result frees the input side in the next cycle.
    a_out_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> o_in_ready)
        else $error("input not ready after the result word was taken");

    // A result without lanes carries zero columns.
    a_zero_cols: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.lanes_valid) |->
        (o_out_data.left_bottom_x == '0 && o_out_data.left_top_x == '0 &&
         o_out_data.right_bottom_x == '0 && o_out_data.right_top_x == '0))
        else $error("nonzero lane column in a result without lanes");

endmodule

/* hdl/lft_mul.sv */
// Shared 64-bit multiplier, modulo 2^64, built from one reused 32x32 multiplier.
module lft_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lft_pkg::t_unit_req i_req,
    output lft_pkg::t_unit_rsp o_rsp
);

    localparam int WW = lft_pkg::WORD_W;
    localparam int HW = lft_pkg::HALF_W;

    localparam logic [1:0] PH_LL = 2'd0;
    localparam logic [1:0] PH_LH = 2'd1;
    localparam logic [1:0] PH_HL = 2'd2;

    logic          r_busy;
    logic          r_done;
    logic [1:0]    r_ph;
    logic [WW-1:0] r_a;
    logic [WW-1:0] r_b;
    logic [WW-1:0] r_lo;
    logic [HW-1:0] r_mid;
    logic [WW-1:0] r_p;
    logic [HW-1:0] op_a;
    logic [HW-1:0] op_b;
    logic [WW-1:0] prod;

    // Pick the half words for the current partial product.
    always_comb begin
        unique case (r_ph)
            PH_LH: begin
                op_a = r_a[HW-1:0];
                op_b = r_b[WW-1:HW];
            end
            PH_HL: begin
                op_a = r_a[WW-1:HW];
                op_b = r_b[HW-1:0];
            end
            default: begin
                op_a = r_a[HW-1:0];
                op_b = r_b[HW-1:0];
            end
        endcase
    end

    assign prod = op_a * op_b;

    // Low product first, then the two cross products that reach the upper half.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= PH_LL;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_busy <= 1'b1;
                r_ph   <= PH_LL;
            end else if (r_busy) begin
                unique case (r_ph)
                    PH_LL: begin
                        r_lo <= prod;
                        r_ph <= PH_LH;
                    end
                    PH_LH: begin
                        r_mid <= prod[HW-1:0];
                        r_ph  <= PH_HL;
                    end
                    default: begin
                        r_p    <= r_lo + {r_mid + prod[HW-1:0], {HW{1'b0}}};
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        r_ph   <= PH_LL;
                    end
                endcase
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_p;

endmodule

/* hdl/lft_div.sv */
// Shared unsigned 64-bit restoring divider, one quotient bit per cycle.
module lft_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lft_pkg::t_unit_req i_req,
    output lft_pkg::t_unit_rsp o_rsp
);

    localparam int WW = lft_pkg::WORD_W;
    localparam int CNW = $clog2(WW);
    localparam logic [CNW-1:0] LAST = CNW'(WW - 1);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [WW-1:0]  r_rem;
    logic [WW-1:0]  r_quo;
    logic [WW-1:0]  r_dvs;
    logic [WW:0]    rem_sh;
    logic [WW:0]    rem_sub;
    logic           ge;

    // Shift in the next dividend bit and try the subtraction.
    assign rem_sh  = {r_rem, r_quo[WW-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign ge      = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_rem  <= '0;
                r_quo  <= i_req.a;
                r_dvs  <= i_req.b;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? rem_sub[WW-1:0] : rem_sh[WW-1:0];
                r_quo <= {r_quo[WW-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_quo;

endmodule
